@@ sv/vgmm_pkg.sv @@
package vgmm_pkg;

    typedef enum logic [3:0] {
        MODE_START  = 4'd0,
        MODE_WORD   = 4'd1,
        MODE_BYTE   = 4'd2,
        MODE_COPY   = 4'd3,
        MODE_HASH   = 4'd4,
        MODE_LOG    = 4'd5,
        MODE_RETURN = 4'd6,
        MODE_REVERT = 4'd7,
        MODE_STOP   = 4'd8,
        MODE_CHARGE = 4'd9
    } mode_t;

    typedef enum logic [2:0] {
        ST_RUN    = 3'd0,
        ST_STOP   = 3'd1,
        ST_RETURN = 3'd2,
        ST_REVERT = 3'd3,
        ST_OOG    = 3'd4,
        ST_OOB    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        REG_START_GAS        = 4'd0,
        REG_MEMORY_WORD_RATE = 4'd1,
        REG_COPY_WORD_RATE   = 4'd2,
        REG_HASH_BASE        = 4'd3,
        REG_HASH_WORD_RATE   = 4'd4,
        REG_LOG_BASE         = 4'd5,
        REG_LOG_TOPIC_RATE   = 4'd6,
        REG_LOG_DATA_RATE    = 4'd7
    } reg_index_t;

    typedef struct packed {
        logic [15:0] memory_word_rate;
        logic [15:0] copy_word_rate;
        logic [15:0] hash_base;
        logic [15:0] hash_word_rate;
        logic [15:0] log_base;
        logic [15:0] log_topic_rate;
        logic [15:0] log_data_rate;
    } rates_t;

    localparam rates_t RATES_RESET = '{
        memory_word_rate: 16'd3,
        copy_word_rate:   16'd3,
        hash_base:        16'd30,
        hash_word_rate:   16'd6,
        log_base:         16'd375,
        log_topic_rate:   16'd375,
        log_data_rate:    16'd8
    };

    // Byte address to word count: round up by WORD_ROUND, shift by WORD_SHIFT.
    localparam int WORD_SHIFT = 5;
    localparam int WORD_ROUND = 31;
    // The quadratic term of the expansion cost is divided by 512.
    localparam int QUAD_SHIFT = 9;

    // Fee sums stay well below 2^50 except the plain charge; one spare bit
    // keeps the compare against the 64-bit gas exact.
    localparam int FEE_W = 65;

endpackage

@@ sv/vgmm_exec.sv @@
module vgmm_exec import vgmm_pkg::*; #(
    parameter int MEMORY_BYTES = 65536,
    parameter int RETURN_LIMIT = 1024,
    parameter int LOG_LIMIT    = 16,
    parameter int TOPIC_LIMIT  = 4,
    localparam int WW = $clog2((MEMORY_BYTES + WORD_ROUND) / 32 + 1),
    localparam int LW = $clog2(LOG_LIMIT + 1)
) (
    input  logic [3:0]    item_mode,
    input  logic [31:0]   item_offset,
    input  logic [31:0]   item_length,
    input  logic [2:0]    item_topic_count,
    input  logic [63:0]   item_amount,
    input  logic [63:0]   start_gas,
    input  rates_t        rates,
    input  logic [63:0]   gas_in,
    input  logic [WW-1:0] words_in,
    input  logic [LW-1:0] logs_in,
    input  status_t       status_in,
    output logic [63:0]   gas_out,
    output logic [WW-1:0] words_out,
    output logic [LW-1:0] logs_out,
    output status_t       status_out
);

    localparam int LB  = $clog2(MEMORY_BYTES + 1);
    localparam int GW  = 2 * WW + 17;
    localparam int CPW = WW + 16;
    localparam int DPW = LB + 16;
    localparam int SQW = 2 * WW;
    localparam int TPW = 19;

    logic [32:0]      len_ext;
    logic             len_over;
    logic             ret_over;
    logic             topic_over;
    logic             logs_full;
    logic [WW-1:0]    len_words;
    logic [LB-1:0]    len_short;
    logic [CPW-1:0]   copy_prod;
    logic [CPW-1:0]   hash_prod;
    logic [TPW-1:0]   topic_prod;
    logic [DPW-1:0]   data_prod;
    logic [31:0]      exp_len;
    logic             exp_none;
    logic [33:0]      end_addr;
    logic [33:0]      end_round;
    logic             end_oob;
    logic [WW-1:0]    end_words;
    logic             grows;
    logic [CPW-1:0]   rate_new;
    logic [CPW-1:0]   rate_old;
    logic [SQW-1:0]   sq_new;
    logic [SQW-1:0]   sq_old;
    logic [GW-1:0]    grow_new;
    logic [GW-1:0]    grow_old;
    logic [FEE_W-1:0] exp_cost;
    logic [FEE_W-1:0] fee1;
    logic [FEE_W-1:0] fee2;
    logic [FEE_W-1:0] sum1;
    logic [FEE_W-1:0] sum2;
    logic [FEE_W-1:0] sum3;
    logic [FEE_W-1:0] gas_ext;
    logic             oob_a;
    logic             oob_b;
    logic             oob_d;
    logic             use_exp;
    logic             count_log;
    logic             active;
    status_t          done_status;

    assign len_ext    = {1'b0, item_length};
    assign len_over   = len_ext > 33'(MEMORY_BYTES);
    assign ret_over   = item_length > 32'(RETURN_LIMIT);
    assign topic_over = {1'b0, item_topic_count} > 4'(TOPIC_LIMIT);
    assign logs_full  = 32'(logs_in) >= 32'(LOG_LIMIT);

    // Word and byte counts of the length only matter once it is known to fit.
    assign len_words  = WW'((len_ext + 33'(WORD_ROUND)) >> WORD_SHIFT);
    assign len_short  = item_length[LB-1:0];
    assign copy_prod  = CPW'(rates.copy_word_rate) * CPW'(len_words);
    assign hash_prod  = CPW'(rates.hash_word_rate) * CPW'(len_words);
    assign topic_prod = TPW'(rates.log_topic_rate) * TPW'(item_topic_count);
    assign data_prod  = DPW'(rates.log_data_rate) * DPW'(len_short);

    always_comb begin
        unique case (mode_t'(item_mode))
            MODE_WORD: exp_len = 32'd32;
            MODE_BYTE: exp_len = 32'd1;
            default:   exp_len = item_length;
        endcase
    end

    assign exp_none  = exp_len == 32'd0;
    assign end_addr  = 34'(item_offset) + 34'(exp_len);
    assign end_round = end_addr + 34'(WORD_ROUND);
    assign end_oob   = !exp_none && (end_addr > 34'(MEMORY_BYTES));
    assign end_words = WW'(end_round >> WORD_SHIFT);
    assign grows     = !exp_none && (end_words > words_in);

    assign rate_new = CPW'(rates.memory_word_rate) * CPW'(end_words);
    assign rate_old = CPW'(rates.memory_word_rate) * CPW'(words_in);
    assign sq_new   = SQW'(end_words) * SQW'(end_words);
    assign sq_old   = SQW'(words_in) * SQW'(words_in);
    assign grow_new = GW'(rate_new) + GW'(sq_new >> QUAD_SHIFT);
    assign grow_old = GW'(rate_old) + GW'(sq_old >> QUAD_SHIFT);
    assign exp_cost = (use_exp && grows) ? FEE_W'(grow_new - grow_old) : '0;

    always_comb begin
        fee1        = '0;
        fee2        = '0;
        oob_a       = 1'b0;
        oob_b       = 1'b0;
        oob_d       = 1'b0;
        use_exp     = 1'b0;
        count_log   = 1'b0;
        active      = 1'b1;
        done_status = ST_RUN;
        unique case (mode_t'(item_mode))
            MODE_WORD, MODE_BYTE: begin
                use_exp = 1'b1;
            end
            MODE_COPY: begin
                oob_a   = len_over;
                fee1    = FEE_W'(copy_prod);
                use_exp = 1'b1;
            end
            MODE_HASH: begin
                oob_a   = len_over;
                fee1    = FEE_W'(rates.hash_base) + FEE_W'(hash_prod);
                use_exp = 1'b1;
            end
            MODE_LOG: begin
                oob_a     = topic_over;
                fee1      = FEE_W'(rates.log_base) + FEE_W'(topic_prod);
                oob_b     = len_over;
                fee2      = FEE_W'(data_prod);
                use_exp   = 1'b1;
                oob_d     = logs_full;
                count_log = 1'b1;
            end
            MODE_RETURN: begin
                oob_a       = len_over || ret_over;
                use_exp     = 1'b1;
                done_status = ST_RETURN;
            end
            MODE_REVERT: begin
                oob_a       = len_over || ret_over;
                use_exp     = 1'b1;
                done_status = ST_REVERT;
            end
            MODE_STOP: begin
                done_status = ST_STOP;
            end
            MODE_CHARGE: begin
                fee1 = {1'b0, item_amount};
            end
            default: begin
                active = 1'b0;
            end
        endcase
    end

    // Running totals of the charges, checked in the order they are taken.
    assign sum1    = fee1;
    assign sum2    = sum1 + fee2;
    assign sum3    = sum2 + exp_cost;
    assign gas_ext = {1'b0, gas_in};

    always_comb begin
        gas_out    = gas_in;
        words_out  = words_in;
        logs_out   = logs_in;
        status_out = status_in;
        if (mode_t'(item_mode) == MODE_START) begin
            gas_out    = start_gas;
            words_out  = '0;
            logs_out   = '0;
            status_out = ST_RUN;
        end else if (status_in == ST_RUN && active) begin
            priority if (oob_a) begin
                gas_out    = '0;
                status_out = ST_OOB;
            end else if (sum1 > gas_ext) begin
                gas_out    = '0;
                status_out = ST_OOG;
            end else if (oob_b) begin
                gas_out    = '0;
                status_out = ST_OOB;
            end else if (sum2 > gas_ext) begin
                gas_out    = '0;
                status_out = ST_OOG;
            end else if (use_exp && end_oob) begin
                gas_out    = '0;
                status_out = ST_OOB;
            end else if (sum3 > gas_ext) begin
                gas_out    = '0;
                status_out = ST_OOG;
            end else if (oob_d) begin
                // The memory has already grown when the log table is found full.
                gas_out    = '0;
                status_out = ST_OOB;
                if (use_exp && grows) begin
                    words_out = end_words;
                end
            end else begin
                gas_out    = gas_in - sum3[63:0];
                status_out = done_status;
                if (use_exp && grows) begin
                    words_out = end_words;
                end
                if (count_log) begin
                    logs_out = logs_in + LW'(1);
                end
            end
        end
    end

endmodule

@@ sv/vm_gas_memory_meter.sv @@
// Each item is held in the input register, and its result beat in the result register.
// Throughput: one item per cycle; the input register and the result register
// both advance whenever the result side takes a beat or the result register is empty.
// The whole charge for one item, including both expansion cost terms, is computed
// combinationally between the two registers.
// Reset clears the meter state to running with zero gas, zero memory and no logs,
// and loads the default rates; there is no clearing pass.
module vm_gas_memory_meter import vgmm_pkg::*; #(
    parameter int MEMORY_BYTES = 65536,
    parameter int RETURN_LIMIT = 1024,
    parameter int LOG_LIMIT    = 16,
    parameter int TOPIC_LIMIT  = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_index,
    input  logic [63:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_mode,
    input  logic [31:0] s_offset,
    input  logic [31:0] s_length,
    input  logic [2:0]  s_topic_count,
    input  logic [63:0] s_amount,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [63:0] m_gas_left,
    output logic [16:0] m_memory_size,
    output logic [4:0]  m_log_count
);

    localparam int WW = $clog2((MEMORY_BYTES + WORD_ROUND) / 32 + 1);
    localparam int LW = $clog2(LOG_LIMIT + 1);

    logic [63:0]   start_gas_reg;
    rates_t        rates_reg;

    logic          in_valid_reg;
    logic [3:0]    in_mode_reg;
    logic [31:0]   in_offset_reg;
    logic [31:0]   in_length_reg;
    logic [2:0]    in_topic_count_reg;
    logic [63:0]   in_amount_reg;

    logic [63:0]   gas_reg;
    logic [WW-1:0] words_reg;
    logic [LW-1:0] logs_reg;
    status_t       status_reg;

    logic [63:0]   gas_next;
    logic [WW-1:0] words_next;
    logic [LW-1:0] logs_next;
    status_t       status_next;

    logic          out_valid_reg;
    status_t       out_status_reg;
    logic [63:0]   out_gas_reg;
    logic [16:0]   out_memory_size_reg;
    logic [4:0]    out_log_count_reg;

    logic          advance;
    logic [31:0]   size_wide;
    logic [31:0]   logs_wide;

    // An item moves on when the result register is free or its beat is taken now.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_gas_reg <= '0;
            rates_reg     <= RATES_RESET;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_START_GAS:        start_gas_reg              <= cfg_wdata;
                REG_MEMORY_WORD_RATE: rates_reg.memory_word_rate <= cfg_wdata[15:0];
                REG_COPY_WORD_RATE:   rates_reg.copy_word_rate   <= cfg_wdata[15:0];
                REG_HASH_BASE:        rates_reg.hash_base        <= cfg_wdata[15:0];
                REG_HASH_WORD_RATE:   rates_reg.hash_word_rate   <= cfg_wdata[15:0];
                REG_LOG_BASE:         rates_reg.log_base         <= cfg_wdata[15:0];
                REG_LOG_TOPIC_RATE:   rates_reg.log_topic_rate   <= cfg_wdata[15:0];
                REG_LOG_DATA_RATE:    rates_reg.log_data_rate    <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_mode_reg        <= s_mode;
            in_offset_reg      <= s_offset;
            in_length_reg      <= s_length;
            in_topic_count_reg <= s_topic_count;
            in_amount_reg      <= s_amount;
        end
    end

    vgmm_exec #(
        .MEMORY_BYTES (MEMORY_BYTES),
        .RETURN_LIMIT (RETURN_LIMIT),
        .LOG_LIMIT    (LOG_LIMIT),
        .TOPIC_LIMIT  (TOPIC_LIMIT)
    ) u_exec (
        .item_mode        (in_mode_reg),
        .item_offset      (in_offset_reg),
        .item_length      (in_length_reg),
        .item_topic_count (in_topic_count_reg),
        .item_amount      (in_amount_reg),
        .start_gas        (start_gas_reg),
        .rates            (rates_reg),
        .gas_in           (gas_reg),
        .words_in         (words_reg),
        .logs_in          (logs_reg),
        .status_in        (status_reg),
        .gas_out          (gas_next),
        .words_out        (words_next),
        .logs_out         (logs_next),
        .status_out       (status_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gas_reg    <= '0;
            words_reg  <= '0;
            logs_reg   <= '0;
            status_reg <= ST_RUN;
        end else if (advance) begin
            gas_reg    <= gas_next;
            words_reg  <= words_next;
            logs_reg   <= logs_next;
            status_reg <= status_next;
        end
    end

    assign size_wide = 32'({words_next, 5'b0});
    assign logs_wide = 32'(logs_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_status_reg      <= status_next;
            out_gas_reg         <= gas_next;
            out_memory_size_reg <= size_wide[16:0];
            out_log_count_reg   <= logs_wide[4:0];
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_gas_left    = out_gas_reg;
    assign m_memory_size = out_memory_size_reg;
    assign m_log_count   = out_log_count_reg;

endmodule
